FILE: sv/vdbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdbt_pkg: shared types and constants for the volume delta bar tracker
// Operation codes, register indexes, controller states and the command word
// that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package vdbt_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned VolW    = 16;
  localparam int unsigned PriceW  = 32;
  localparam int unsigned SumW    = 32;
  localparam int unsigned CumW    = 48;
  localparam int unsigned PctW    = 15;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned QuoW    = 14;   // percent quotient never exceeds 10000
  localparam int unsigned StepW   = 4;
  localparam int unsigned MulAW   = 17;
  localparam int unsigned MulBW   = 32;
  localparam int unsigned ProdW   = MulAW + MulBW;

  localparam logic [OpW-1:0] OpTick    = 2'd0;
  localparam logic [OpW-1:0] OpBarClose = 2'd1;
  localparam logic [OpW-1:0] OpSession = 2'd2;
  localparam logic [OpW-1:0] OpSpare   = 2'd3;   // no effect, no result

  localparam logic [CfgIdxW-1:0] RegEmaAlpha  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSurgeThr  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegExtremeThr = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSmallThr  = 2'd3;

  localparam logic [CfgW-1:0] EmaAlphaRst   = 16'd6554;
  localparam logic [CfgW-1:0] SurgeThrRst   = 16'd512;
  localparam logic [CfgW-1:0] ExtremeThrRst = 16'd52429;
  localparam logic [CfgW-1:0] SmallThrRst   = 16'd6554;

  localparam logic [MulAW-1:0] PctScale = 17'd10000;
  localparam logic [MulAW-1:0] EmaOne   = 17'd65536;

  localparam logic [1:0] DivNone  = 2'd0;
  localparam logic [1:0] DivLong  = 2'd1;
  localparam logic [1:0] DivShort = 2'd2;

  localparam logic [2:0] SurgeNone     = 3'd0;
  localparam logic [2:0] SurgeBull     = 3'd1;
  localparam logic [2:0] SurgeBullVery = 3'd2;
  localparam logic [2:0] SurgeBear     = 3'd3;
  localparam logic [2:0] SurgeBearVery = 3'd4;

  localparam logic [1:0] ExtNone  = 2'd0;
  localparam logic [1:0] ExtLong  = 2'd1;
  localparam logic [1:0] ExtShort = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MPCT, S_MA, S_MB, S_EMA, S_MS, S_ME, S_MR, S_SMALL,
    S_DIV, S_OUT
  } state_e;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_PCT, MUL_ALPHA, MUL_BETA, MUL_SURGE, MUL_EXT, MUL_SMALL
  } mul_sel_e;

  typedef struct packed {
    logic             tick_en;
    logic             sess_clr;
    logic             close_latch;
    logic             load;
    mul_sel_e         mul_sel;
    logic             div_init;
    logic             acc_save;
    logic             ema_upd;
    logic             surge_eval;
    logic             ext_eval;
    logic             small_eval;
    logic             div_step;
    logic [StepW-1:0] div_shift;
    logic             out_load;
  } cmd_t;

endpackage

FILE: sv/vdbt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdbt interfaces: input, result and configuration channels
// Valid/ready channels; a word moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface vdbt_in_if;
  logic                               valid;
  logic                               ready;
  logic [vdbt_pkg::OpW-1:0]           op;
  logic                               side_is_ask;
  logic                               counts_toward_delta;
  logic [vdbt_pkg::VolW-1:0]          tick_volume;
  logic [vdbt_pkg::PriceW-1:0]        open_price;
  logic [vdbt_pkg::PriceW-1:0]        close_price;
  modport source (output valid, op, side_is_ask, counts_toward_delta, tick_volume,
                  open_price, close_price, input ready);
  modport sink (input valid, op, side_is_ask, counts_toward_delta, tick_volume,
                open_price, close_price, output ready);
endinterface

interface vdbt_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [31:0]                 net_delta;
  logic [30:0]                        bar_peak_delta;
  logic signed [31:0]                 bar_trough_delta;
  logic signed [vdbt_pkg::CumW-1:0]   session_cum_delta;
  logic [31:0]                        total_volume;
  logic signed [vdbt_pkg::PctW-1:0]   delta_percent;
  logic [1:0]                         divergence;
  logic [2:0]                         surge;
  logic [1:0]                         extreme;
  logic                               small_range;
  modport source (output valid, net_delta, bar_peak_delta, bar_trough_delta,
                  session_cum_delta, total_volume, delta_percent, divergence, surge,
                  extreme, small_range, input ready);
  modport sink (input valid, net_delta, bar_peak_delta, bar_trough_delta,
                session_cum_delta, total_volume, delta_percent, divergence, surge,
                extreme, small_range, output ready);
endinterface

interface vdbt_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [vdbt_pkg::CfgIdxW-1:0]       index;
  logic [vdbt_pkg::CfgW-1:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/vdbt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdbt_ctrl: sequencer for the bar tracker
// Takes words in idle, walks a bar close through multiplies and the divide,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module vdbt_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [vdbt_pkg::OpW-1:0]     in_op_i,
  output logic                         in_ready_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output vdbt_pkg::cmd_t               cmd_o
);

  vdbt_pkg::state_e state_q, state_d;
  logic [vdbt_pkg::StepW-1:0] step_q, step_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vdbt_pkg::S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    cmd_o.mul_sel = vdbt_pkg::MUL_NONE;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      vdbt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_op_i)
            vdbt_pkg::OpTick:    cmd_o.tick_en = 1'b1;
            vdbt_pkg::OpSession: cmd_o.sess_clr = 1'b1;
            vdbt_pkg::OpBarClose: begin
              cmd_o.close_latch = 1'b1;
              state_d = vdbt_pkg::S_LOAD;
            end
            default: ;
          endcase
        end
      end
      vdbt_pkg::S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d = vdbt_pkg::S_MPCT;
      end
      vdbt_pkg::S_MPCT: begin
        cmd_o.mul_sel = vdbt_pkg::MUL_PCT;
        state_d = vdbt_pkg::S_MA;
      end
      vdbt_pkg::S_MA: begin
        cmd_o.mul_sel  = vdbt_pkg::MUL_ALPHA;
        cmd_o.div_init = 1'b1;
        state_d = vdbt_pkg::S_MB;
      end
      vdbt_pkg::S_MB: begin
        cmd_o.mul_sel  = vdbt_pkg::MUL_BETA;
        cmd_o.acc_save = 1'b1;
        state_d = vdbt_pkg::S_EMA;
      end
      vdbt_pkg::S_EMA: begin
        cmd_o.ema_upd = 1'b1;
        state_d = vdbt_pkg::S_MS;
      end
      vdbt_pkg::S_MS: begin
        cmd_o.mul_sel = vdbt_pkg::MUL_SURGE;
        state_d = vdbt_pkg::S_ME;
      end
      vdbt_pkg::S_ME: begin
        cmd_o.mul_sel    = vdbt_pkg::MUL_EXT;
        cmd_o.surge_eval = 1'b1;
        state_d = vdbt_pkg::S_MR;
      end
      vdbt_pkg::S_MR: begin
        cmd_o.mul_sel  = vdbt_pkg::MUL_SMALL;
        cmd_o.ext_eval = 1'b1;
        state_d = vdbt_pkg::S_SMALL;
      end
      vdbt_pkg::S_SMALL: begin
        cmd_o.small_eval = 1'b1;
        step_d  = vdbt_pkg::StepW'(vdbt_pkg::QuoW - 1);
        state_d = vdbt_pkg::S_DIV;
      end
      vdbt_pkg::S_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_shift = step_q;
        if (step_q == '0) begin
          state_d = vdbt_pkg::S_OUT;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      vdbt_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = vdbt_pkg::S_IDLE;
        end
      end
      default: state_d = vdbt_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/vdbt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdbt_dp: datapath of the bar tracker
// Bar and session accumulators, config registers, one shared 17x32
// multiplier, a restoring divider for delta percent and the result register.
// ----------------------------------------------------------------------------
module vdbt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vdbt_pkg::cmd_t                cmd_i,
  input  logic                          cfg_we_i,
  input  logic [vdbt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [vdbt_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          side_is_ask_i,
  input  logic                          counts_i,
  input  logic [vdbt_pkg::VolW-1:0]     tick_volume_i,
  input  logic [vdbt_pkg::PriceW-1:0]   open_price_i,
  input  logic [vdbt_pkg::PriceW-1:0]   close_price_i,
  output logic signed [31:0]            net_delta_o,
  output logic [30:0]                   bar_peak_delta_o,
  output logic signed [31:0]            bar_trough_delta_o,
  output logic signed [vdbt_pkg::CumW-1:0] session_cum_delta_o,
  output logic [31:0]                   total_volume_o,
  output logic signed [vdbt_pkg::PctW-1:0] delta_percent_o,
  output logic [1:0]                    divergence_o,
  output logic [2:0]                    surge_o,
  output logic [1:0]                    extreme_o,
  output logic                          small_range_o
);

  localparam int unsigned RemW = 46;
  localparam int unsigned CfgW = vdbt_pkg::CfgW;

  logic [CfgW-1:0] alpha_q, thr_s_q, thr_e_q, thr_r_q;

  logic [31:0]        ask_q, bid_q;
  logic signed [31:0] rd_q, pk_q, tr_q;
  logic signed [47:0] cum_q;
  logic signed [31:0] spk_q, str_q;
  logic [31:0]        avg_q;

  logic [31:0]        open_q, close_q;
  logic signed [31:0] d_q;
  logic [31:0]        vol_q, ad_q;
  logic [vdbt_pkg::ProdW-1:0] prod_q;
  logic [vdbt_pkg::ProdW:0]   acc_q;
  logic [RemW-1:0]            rem_q;
  logic [vdbt_pkg::QuoW-1:0]  quo_q;
  logic [2:0] surge_q;
  logic [1:0] ext_q, div_q;
  logic       small_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= vdbt_pkg::EmaAlphaRst;
      thr_s_q <= vdbt_pkg::SurgeThrRst;
      thr_e_q <= vdbt_pkg::ExtremeThrRst;
      thr_r_q <= vdbt_pkg::SmallThrRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vdbt_pkg::RegEmaAlpha:   alpha_q <= cfg_data_i;
        vdbt_pkg::RegSurgeThr:   thr_s_q <= cfg_data_i;
        vdbt_pkg::RegExtremeThr: thr_e_q <= cfg_data_i;
        vdbt_pkg::RegSmallThr:   thr_r_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // tick path
  logic [32:0]        side_sum;
  logic [31:0]        side_sat;
  logic signed [32:0] rd_sum;
  logic signed [31:0] rd_sat;
  always_comb begin
    side_sum = {1'b0, (side_is_ask_i ? ask_q : bid_q)} + {17'b0, tick_volume_i};
    side_sat = side_sum[32] ? '1 : side_sum[31:0];
    if (side_is_ask_i) rd_sum = {rd_q[31], rd_q} + $signed({17'b0, tick_volume_i});
    else               rd_sum = {rd_q[31], rd_q} - $signed({17'b0, tick_volume_i});
    if (rd_sum[32] != rd_sum[31]) rd_sat = rd_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else                          rd_sat = rd_sum[31:0];
  end

  // bar close values
  logic signed [32:0] diff_c;
  logic signed [31:0] d_c;
  logic [32:0]        vsum_c;
  logic signed [48:0] cum_sum_c;
  always_comb begin
    diff_c = $signed({1'b0, ask_q}) - $signed({1'b0, bid_q});
    if (diff_c[32] != diff_c[31]) d_c = diff_c[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else                          d_c = diff_c[31:0];
    vsum_c    = {1'b0, ask_q} + {1'b0, bid_q};
    cum_sum_c = {cum_q[47], cum_q} + {{17{d_c[31]}}, d_c};
  end

  logic [31:0] mag_pk, mag_tr, m_c;
  always_comb begin
    mag_pk = spk_q[31] ? 32'(-spk_q) : 32'(spk_q);
    mag_tr = str_q[31] ? 32'(-str_q) : 32'(str_q);
    m_c    = (mag_pk > mag_tr) ? mag_pk : mag_tr;
  end

  // shared multiplier
  logic [vdbt_pkg::MulAW-1:0] mul_a;
  logic [vdbt_pkg::MulBW-1:0] mul_b;
  always_comb begin
    case (cmd_i.mul_sel)
      vdbt_pkg::MUL_PCT:   begin mul_a = vdbt_pkg::PctScale; mul_b = ad_q; end
      vdbt_pkg::MUL_ALPHA: begin mul_a = {1'b0, alpha_q}; mul_b = ad_q; end
      vdbt_pkg::MUL_BETA:  begin mul_a = vdbt_pkg::EmaOne - {1'b0, alpha_q}; mul_b = avg_q; end
      vdbt_pkg::MUL_SURGE: begin mul_a = {1'b0, thr_s_q}; mul_b = avg_q; end
      vdbt_pkg::MUL_EXT:   begin mul_a = {1'b0, thr_e_q}; mul_b = m_c; end
      vdbt_pkg::MUL_SMALL: begin mul_a = {1'b0, thr_r_q}; mul_b = vol_q; end
      default:             begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  logic [vdbt_pkg::ProdW:0] ema_sum;
  logic [RemW-1:0]          div_sub;
  logic [31:0]              range_c;
  assign ema_sum = acc_q + {1'b0, prod_q};
  assign div_sub = {14'b0, vol_q} << cmd_i.div_shift;
  assign range_c = 32'(pk_q - tr_q);

  // state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ask_q <= '0; bid_q <= '0; rd_q <= '0; pk_q <= '0; tr_q <= '0;
      cum_q <= '0; spk_q <= '0; str_q <= '0; avg_q <= '0;
    end else begin
      if (cmd_i.tick_en && counts_i) begin
        if (side_is_ask_i) ask_q <= side_sat;
        else               bid_q <= side_sat;
        rd_q <= rd_sat;
        if (rd_sat > pk_q) pk_q <= rd_sat;
        if (rd_sat < tr_q) tr_q <= rd_sat;
      end
      if (cmd_i.sess_clr || cmd_i.out_load) begin
        ask_q <= '0; bid_q <= '0; rd_q <= '0; pk_q <= '0; tr_q <= '0;
      end
      if (cmd_i.sess_clr) begin
        cum_q <= '0; spk_q <= '0; str_q <= '0; avg_q <= '0;
      end
      if (cmd_i.load) begin
        if (cum_sum_c[48] != cum_sum_c[47])
          cum_q <= cum_sum_c[48] ? 48'sh8000_0000_0000 : 48'sh7fff_ffff_ffff;
        else
          cum_q <= cum_sum_c[47:0];
        if (d_c > spk_q) spk_q <= d_c;
        if (d_c < str_q) str_q <= d_c;
      end
      if (cmd_i.ema_upd) begin
        avg_q <= (avg_q == '0) ? ad_q : ema_sum[47:16];
      end
    end
  end

  // per-bar working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.close_latch) begin
      open_q  <= open_price_i;
      close_q <= close_price_i;
    end
    if (cmd_i.load) begin
      d_q   <= d_c;
      vol_q <= vsum_c[32] ? '1 : vsum_c[31:0];
      ad_q  <= d_c[31] ? 32'(-d_c) : 32'(d_c);
    end
    if (cmd_i.div_init) begin
      rem_q <= prod_q[RemW-1:0];
      quo_q <= '0;
    end
    if (cmd_i.acc_save) acc_q <= {1'b0, prod_q};
    if (cmd_i.surge_eval) begin
      surge_q <= vdbt_pkg::SurgeNone;
      if (avg_q != '0 && {9'b0, ad_q, 8'b0} >= prod_q) begin
        if ({10'b0, ad_q, 8'b0} >= {prod_q, 1'b0})
          surge_q <= (d_q > 0) ? vdbt_pkg::SurgeBullVery : vdbt_pkg::SurgeBearVery;
        else
          surge_q <= (d_q > 0) ? vdbt_pkg::SurgeBull : vdbt_pkg::SurgeBear;
      end
    end
    if (cmd_i.ext_eval) begin
      ext_q <= vdbt_pkg::ExtNone;
      if (m_c != '0 && {1'b0, ad_q, 16'b0} >= prod_q)
        ext_q <= (d_q > 0) ? vdbt_pkg::ExtLong : vdbt_pkg::ExtShort;
    end
    if (cmd_i.small_eval) begin
      small_q <= (vol_q != '0) && ({1'b0, range_c, 16'b0} < prod_q);
      if (close_q < open_q && d_q > 0)      div_q <= vdbt_pkg::DivLong;
      else if (close_q > open_q && d_q < 0) div_q <= vdbt_pkg::DivShort;
      else                                  div_q <= vdbt_pkg::DivNone;
    end
    // zero volume leaves the quotient at zero
    if (cmd_i.div_step && vol_q != '0 && rem_q >= div_sub) begin
      rem_q <= rem_q - div_sub;
      quo_q[cmd_i.div_shift] <= 1'b1;
    end
  end

  // result register
  logic signed [vdbt_pkg::PctW-1:0] pct_c;
  assign pct_c = d_q[31] ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      net_delta_o         <= d_q;
      bar_peak_delta_o    <= pk_q[30:0];
      bar_trough_delta_o  <= tr_q;
      session_cum_delta_o <= cum_q;
      total_volume_o      <= vol_q;
      delta_percent_o     <= pct_c;
      divergence_o        <= div_q;
      surge_o             <= surge_q;
      extreme_o           <= ext_q;
      small_range_o       <= small_q;
    end
  end

endmodule

FILE: sv/volume_delta_bar_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_delta_bar_tracker: cumulative volume delta per bar and session
// Top level: controller plus datapath, with input, result and config channels.
// ----------------------------------------------------------------------------
// Ticks and session opens are taken in idle and leave the block there, so it
// stays ready for the next word. A bar close, once accepted, passes through a
// load state, then states of work on the single shared 17x32 multiplier for
// percent scaling, the EMA and the three detector thresholds, then a 14-step
// restoring divide for delta percent, before its result word is loaded; the
// load waits while the previous result word still waits at the output. While
// a close is in progress no input word is taken. The result sits in an output
// register, so ticks of the next bar are accepted while it waits. Config
// writes are always ready and take effect at once; write them while idle.
// ----------------------------------------------------------------------------
module volume_delta_bar_tracker (
  input  logic          clk_i,
  input  logic          rst_ni,
  vdbt_in_if.sink       in_i,
  vdbt_out_if.source    out_o,
  vdbt_cfg_if.sink      cfg_i
);

  vdbt_pkg::cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  // sequencer: owns acceptance and result valid
  vdbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.op),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  // accumulators, arithmetic and result payload
  vdbt_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .cfg_we_i            (cfg_i.valid),
    .cfg_index_i         (cfg_i.index),
    .cfg_data_i          (cfg_i.data),
    .side_is_ask_i       (in_i.side_is_ask),
    .counts_i            (in_i.counts_toward_delta),
    .tick_volume_i       (in_i.tick_volume),
    .open_price_i        (in_i.open_price),
    .close_price_i       (in_i.close_price),
    .net_delta_o         (out_o.net_delta),
    .bar_peak_delta_o    (out_o.bar_peak_delta),
    .bar_trough_delta_o  (out_o.bar_trough_delta),
    .session_cum_delta_o (out_o.session_cum_delta),
    .total_volume_o      (out_o.total_volume),
    .delta_percent_o     (out_o.delta_percent),
    .divergence_o        (out_o.divergence),
    .surge_o             (out_o.surge),
    .extreme_o           (out_o.extreme),
    .small_range_o       (out_o.small_range)
  );

endmodule
